@@ hw/rtl/fllrs_pkg.sv @@
package fllrs_pkg;

    localparam logic [31:0] ERASED_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam int          HEADER_BYTES = 16;
    localparam int          HEADER_BITS  = HEADER_BYTES * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAGIC_VALUE    = 3'd0,
        CFG_VERSION_VALUE  = 3'd1,
        CFG_CLOCK_MIN      = 3'd2,
        CFG_CLOCK_MAX      = 3'd3,
        CFG_CLOCK_DEFAULT  = 3'd4,
        CFG_CLOCK_SAFE_MAX = 3'd5
    } cfg_index_t;

endpackage

@@ hw/rtl/fllrs_crc32.sv @@
module fllrs_crc32 (
    input  logic [fllrs_pkg::HEADER_BITS-1:0] header,
    output logic [31:0]                       crc
);
    import fllrs_pkg::*;

    // Reflected CRC-32, one header bit per step, LSB of byte 0 first.
    // The data is fixed width, so this flattens into one XOR tree per bit.
    function automatic logic [31:0] crc_of(input logic [HEADER_BITS-1:0] data);
        logic [31:0] c;
        c = CRC_INIT;
        for (int i = 0; i < HEADER_BITS; i++)
        begin
            if (c[0] ^ data[i])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return ~c;
    endfunction

    assign crc = crc_of(header);

endmodule

@@ hw/rtl/flash_log_latest_record_scan.sv @@
// Latest-record scan of one flash log sector. Feed the sector's record slots
// in slot order, one transaction per slot, with last_slot set on the final
// slot; one result transaction follows that slot, and the scan state clears
// for the next sector. A slot is valid when magic, version, stored CRC-32
// (reflected, over the 16 header bytes) and clock range all match; an erased
// slot (all-ones magic) marks the first free slot and ends the scan, and
// slots after it, or beyond SLOT_COUNT, are ignored until the sector ends.
// Rate: one slot per clock cycle, sustained. A slot waits in the input
// register, where the CRC tree and the checks run, and the scan state
// updates as it leaves; the result register loads as the last slot
// leaves the input register. The single result register sets the only
// stall: a last slot waits in the input register while the previous
// sector's result is still untaken. Write configuration only while the
// block is idle.
module flash_log_latest_record_scan #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [fllrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fllrs_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [31:0]                          rec_magic,
    input  logic [15:0]                          rec_version,
    input  logic [15:0]                          rec_clock,
    input  logic [7:0]                           rec_cores,
    input  logic [63:0]                          header_low,
    input  logic [63:0]                          header_high,
    input  logic [31:0]                          stored_crc,
    input  logic                                 last_slot,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic [3:0]                           latest_slot,
    output logic [15:0]                          latest_clock,
    output logic [7:0]                           latest_cores,
    output logic [3:0]                           free_slot,
    output logic                                 sector_full,
    output logic [15:0]                          apply_clock
);
    import fllrs_pkg::*;

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] magic_value_reg;
    logic [15:0] version_value_reg;
    logic [15:0] clock_min_reg;
    logic [15:0] clock_max_reg;
    logic [15:0] clock_default_reg;
    logic [15:0] clock_safe_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_value_reg    <= '0;
            version_value_reg  <= '0;
            clock_min_reg      <= '0;
            clock_max_reg      <= '0;
            clock_default_reg  <= '0;
            clock_safe_max_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAGIC_VALUE:    magic_value_reg    <= cfg_data;
                CFG_VERSION_VALUE:  version_value_reg  <= cfg_data[15:0];
                CFG_CLOCK_MIN:      clock_min_reg      <= cfg_data[15:0];
                CFG_CLOCK_MAX:      clock_max_reg      <= cfg_data[15:0];
                CFG_CLOCK_DEFAULT:  clock_default_reg  <= cfg_data[15:0];
                CFG_CLOCK_SAFE_MAX: clock_safe_max_reg <= cfg_data[15:0];
                default:            ; // drop writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one slot while it is checked
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [31:0] s1_magic_reg;
    logic [15:0] s1_version_reg;
    logic [15:0] s1_clock_reg;
    logic [7:0]  s1_cores_reg;
    logic [HEADER_BITS-1:0] s1_header_reg;
    logic [31:0] s1_crc_reg;
    logic        s1_last_reg;

    logic s1_adv;
    logic in_fire;

    // A slot that is not last never needs the result register, so it always
    // moves on; a last slot moves on only if the result register can take it.
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !out_valid || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_magic_reg   <= rec_magic;
            s1_version_reg <= rec_version;
            s1_clock_reg   <= rec_clock;
            s1_cores_reg   <= rec_cores;
            s1_header_reg  <= {header_high, header_low};
            s1_crc_reg     <= stored_crc;
            s1_last_reg    <= last_slot;
        end
    end

    // ------------------------------------------------------------------
    // Slot checks
    // ------------------------------------------------------------------
    logic [31:0] calc_crc;

    fllrs_crc32 u_crc (
        .header (s1_header_reg),
        .crc    (calc_crc)
    );

    // Scan state
    logic [CNT_W-1:0] cnt_reg,         cnt_next;
    logic             stopped_reg,     stopped_next;
    logic             have_valid_reg,  have_valid_next;
    logic [3:0]       best_slot_reg,   best_slot_next;
    logic [15:0]      best_clock_reg,  best_clock_next;
    logic [7:0]       best_cores_reg,  best_cores_next;
    logic             have_erased_reg, have_erased_next;
    logic [3:0]       erased_slot_reg, erased_slot_next;

    logic in_range;
    logic live;
    logic is_erased;
    logic rec_ok;
    logic clock_ok;

    assign in_range  = cnt_reg < SLOT_LIMIT;
    assign live      = !stopped_reg && in_range;
    assign is_erased = s1_magic_reg == ERASED_WORD;
    assign clock_ok  = (s1_clock_reg == 16'd0)
                    || ((s1_clock_reg >= clock_min_reg) && (s1_clock_reg <= clock_max_reg));
    assign rec_ok    = (s1_magic_reg == magic_value_reg)
                    && (s1_version_reg == version_value_reg)
                    && (s1_crc_reg == calc_crc)
                    && clock_ok;

    // Scan state after this slot, before the end-of-sector clear
    logic             upd_valid;
    logic [3:0]       upd_slot;
    logic [15:0]      upd_clock;
    logic [7:0]       upd_cores;
    logic             upd_erased;
    logic [3:0]       upd_erased_slot;
    logic             upd_stopped;
    logic [CNT_W-1:0] upd_cnt;

    always_comb
    begin
        upd_valid       = have_valid_reg;
        upd_slot        = best_slot_reg;
        upd_clock       = best_clock_reg;
        upd_cores       = best_cores_reg;
        upd_erased      = have_erased_reg;
        upd_erased_slot = erased_slot_reg;
        upd_stopped     = stopped_reg;
        if (live)
        begin
            if (is_erased)
            begin
                // Erased wins even when magic_value is all ones too
                upd_stopped     = 1'b1;
                upd_erased      = 1'b1;
                upd_erased_slot = 4'(cnt_reg);
            end
            else if (rec_ok)
            begin
                upd_valid = 1'b1;
                upd_slot  = 4'(cnt_reg);
                upd_clock = s1_clock_reg;
                upd_cores = s1_cores_reg;
            end
        end
        // Saturate the counter so slots past the sector size stay ignored
        upd_cnt = in_range ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    always_comb
    begin
        cnt_next         = cnt_reg;
        stopped_next     = stopped_reg;
        have_valid_next  = have_valid_reg;
        best_slot_next   = best_slot_reg;
        best_clock_next  = best_clock_reg;
        best_cores_next  = best_cores_reg;
        have_erased_next = have_erased_reg;
        erased_slot_next = erased_slot_reg;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                // Start afresh for the next sector
                cnt_next         = '0;
                stopped_next     = 1'b0;
                have_valid_next  = 1'b0;
                best_slot_next   = '0;
                best_clock_next  = '0;
                best_cores_next  = '0;
                have_erased_next = 1'b0;
                erased_slot_next = '0;
            end
            else
            begin
                cnt_next         = upd_cnt;
                stopped_next     = upd_stopped;
                have_valid_next  = upd_valid;
                best_slot_next   = upd_slot;
                best_clock_next  = upd_clock;
                best_cores_next  = upd_cores;
                have_erased_next = upd_erased;
                erased_slot_next = upd_erased_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            stopped_reg     <= 1'b0;
            have_valid_reg  <= 1'b0;
            best_slot_reg   <= '0;
            best_clock_reg  <= '0;
            best_cores_reg  <= '0;
            have_erased_reg <= 1'b0;
            erased_slot_reg <= '0;
        end
        else
        begin
            cnt_reg         <= cnt_next;
            stopped_reg     <= stopped_next;
            have_valid_reg  <= have_valid_next;
            best_slot_reg   <= best_slot_next;
            best_clock_reg  <= best_clock_next;
            best_cores_reg  <= best_cores_next;
            have_erased_reg <= have_erased_next;
            erased_slot_reg <= erased_slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        out_valid_reg, out_valid_next;
    logic        found_reg;
    logic [3:0]  latest_slot_reg;
    logic [15:0] latest_clock_reg;
    logic [7:0]  latest_cores_reg;
    logic [3:0]  free_slot_reg;
    logic        sector_full_reg;
    logic [15:0] apply_clock_reg;

    logic        emit;
    logic [15:0] rec_or_default;
    logic [15:0] apply_next;

    assign emit = s1_adv && s1_last_reg;

    // Zero clock means default; so does no valid record, and anything above the safe limit falls back too
    always_comb
    begin
        rec_or_default = (upd_clock != 16'd0) ? upd_clock : clock_default_reg;
        if (!upd_valid || (rec_or_default > clock_safe_max_reg))
        begin
            apply_next = clock_default_reg;
        end
        else
        begin
            apply_next = rec_or_default;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg        <= upd_valid;
            latest_slot_reg  <= upd_valid ? upd_slot  : 4'd0;
            latest_clock_reg <= upd_valid ? upd_clock : 16'd0;
            latest_cores_reg <= upd_valid ? upd_cores : 8'd0;
            free_slot_reg    <= upd_erased ? upd_erased_slot : 4'd0;
            sector_full_reg  <= !upd_erased;
            apply_clock_reg  <= apply_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign latest_slot  = latest_slot_reg;
    assign latest_clock = latest_clock_reg;
    assign latest_cores = latest_cores_reg;
    assign free_slot    = free_slot_reg;
    assign sector_full  = sector_full_reg;
    assign apply_clock  = apply_clock_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_blocks_on_full_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid && !out_ready) |-> !in_ready
    ) else $error("last slot advanced into an untaken result register");

    a_clear_after_sector: assert property (
        @(posedge clk) disable iff (!rst_n)
        emit |=> (cnt_reg == '0 && !have_valid_reg && !have_erased_reg && !stopped_reg)
    ) else $error("scan state not cleared after the last slot");

    a_empty_result_is_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |->
            (latest_slot == 4'd0 && latest_clock == 16'd0 && latest_cores == 8'd0
             && apply_clock == clock_default_reg)
    ) else $error("result without a record carries nonzero fields");

    a_full_sector_free_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && sector_full) |-> (free_slot == 4'd0)
    ) else $error("full sector reports a free slot");

endmodule
